FILE: hw/rtl/tcprst_pkg.sv
`default_nettype none

package tcprst_pkg;

  // reply layout
  localparam int unsigned WordsMax = 8;
  localparam int unsigned IdxW     = $clog2(WordsMax);

  localparam logic [IdxW-1:0] LastIdxV4 = IdxW'(4);
  localparam logic [IdxW-1:0] LastIdxV6 = IdxW'(7);

  localparam logic [3:0] BytesFull   = 4'd8;
  localparam logic [3:0] BytesV6Tail = 4'd4;

  // bits of the original flags byte
  localparam int unsigned FlagAckBit = 4;
  localparam int unsigned FlagSynBit = 1;
  localparam int unsigned FlagFinBit = 0;

  localparam logic [7:0] RstFlags    = 8'h04;
  localparam logic [7:0] RstAckFlags = 8'h14;
  localparam logic [7:0] TcpOffset   = 8'h50;
  localparam logic [7:0] ProtoTcp    = 8'd6;
  localparam logic [7:0] TtlHops     = 8'd64;

  // version/ihl, total length 40, id 0, DF
  localparam logic [63:0] V4Word0 = 64'h4500_0028_0000_4000;
  // version 6, payload length 20, next header tcp, hop limit 64
  localparam logic [63:0] V6Word0 = 64'h6000_0000_0014_0640;

  // fixed ipv4 header words: 4500 + 0028 + 4000 + 4006
  localparam logic [15:0] Ipv4SumBase   = 16'hC52E;
  // pseudo-header protocol 6 plus tcp length 20
  localparam logic [15:0] PseudoSumBase = 16'd26;

  localparam int unsigned Sum4W   = 18;
  localparam int unsigned TcpSumW = 19;
  localparam int unsigned TotalW  = 21;

  typedef struct packed {
    logic        is_v6;
    logic [63:0] peer_addr_hi;
    logic [63:0] peer_addr_lo;
    logic [63:0] local_addr_hi;
    logic [63:0] local_addr_lo;
    logic [15:0] peer_port;
    logic [15:0] local_port;
    logic [31:0] seq_in;
    logic [31:0] ack_in;
    logic [7:0]  flags_in;
    logic [15:0] l3_length;
    logic [15:0] header_length;
  } req_t;

  typedef struct packed {
    logic        is_v6;
    logic [63:0] peer_addr_hi;
    logic [63:0] peer_addr_lo;
    logic [63:0] local_addr_hi;
    logic [63:0] local_addr_lo;
    logic [15:0] peer_port;
    logic [15:0] local_port;
    logic [31:0] seq_out;
    logic [31:0] ack_out;
    logic [7:0]  flags_out;
  } hdr_t;

  typedef struct packed {
    hdr_t               hdr;
    logic [Sum4W-1:0]   local_hi_sum;
    logic [Sum4W-1:0]   local_lo_sum;
    logic [Sum4W-1:0]   peer_hi_sum;
    logic [Sum4W-1:0]   peer_lo_sum;
    logic [TcpSumW-1:0] tcp_sum;
  } sums_t;

  typedef struct packed {
    logic [WordsMax-1:0][63:0] words;
    logic                      is_v6;
    logic [IdxW-1:0]           last_idx;
  } pkt_t;

  function automatic logic [Sum4W-1:0] sum4(input logic [63:0] x);
    return Sum4W'(x[63:48]) + Sum4W'(x[47:32]) + Sum4W'(x[31:16]) + Sum4W'(x[15:0]);
  endfunction

  // two end-around folds are enough below 2^21, then complement
  function automatic logic [15:0] csum_fold(input logic [TotalW-1:0] s);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = 17'(s[TotalW-1:16]) + 17'(s[15:0]);
    s2 = 17'(s1[16]) + 17'(s1[15:0]);
    return ~s2[15:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tcprst_if.sv
`default_nettype none

interface tcprst_in_if;
  logic        valid;
  logic        ready;
  logic        is_v6;
  logic [63:0] peer_addr_hi;
  logic [63:0] peer_addr_lo;
  logic [63:0] local_addr_hi;
  logic [63:0] local_addr_lo;
  logic [15:0] peer_port;
  logic [15:0] local_port;
  logic [31:0] seq_in;
  logic [31:0] ack_in;
  logic [7:0]  flags_in;
  logic [15:0] l3_length;
  logic [15:0] header_length;

  modport source (
    output valid, is_v6, peer_addr_hi, peer_addr_lo, local_addr_hi, local_addr_lo,
           peer_port, local_port, seq_in, ack_in, flags_in, l3_length, header_length,
    input  ready
  );

  modport sink (
    input  valid, is_v6, peer_addr_hi, peer_addr_lo, local_addr_hi, local_addr_lo,
           peer_port, local_port, seq_in, ack_in, flags_in, l3_length, header_length,
    output ready
  );
endinterface

interface tcprst_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] packet_word;
  logic [3:0]  valid_bytes;
  logic        last_word;

  modport source (
    output valid, packet_word, valid_bytes, last_word,
    input  ready
  );

  modport sink (
    input  valid, packet_word, valid_bytes, last_word,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/tcp_reset_builder.sv
// channel | dir | payload                                        | accepted when
// in_i    | in  | is_v6, addresses, ports, seq/ack, flags, lengths | valid && ready
// out_o   | out | packet_word, valid_bytes, last_word            | valid && ready
//
// one request per reply; an IPv4 reply is 5 words, an IPv6 reply is 8 words,
// so the output word stream, held by any back-pressure on out_o, sets the request rate.
// four register stages (input, seq/ack, checksum partials, assembled packet)
// ahead of the word serializer.
// reset clears the stage valid flags and the serializer word index.
// a stage advances when the next is empty or draining, so the pipe keeps filling.
`default_nettype none

module tcp_reset_builder
  import tcprst_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  tcprst_in_if.sink    in_i,
  tcprst_out_if.source out_o
);

  hdr_t hdr;
  logic hdr_valid;
  logic hdr_ready;
  pkt_t pkt;
  logic pkt_valid;
  logic pkt_ready;

  tcprst_seg u_seg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .hdr_o       (hdr),
    .hdr_valid_o (hdr_valid),
    .hdr_ready_i (hdr_ready)
  );

  tcprst_csum u_csum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hdr_i       (hdr),
    .hdr_valid_i (hdr_valid),
    .hdr_ready_o (hdr_ready),
    .pkt_o       (pkt),
    .pkt_valid_o (pkt_valid),
    .pkt_ready_i (pkt_ready)
  );

  tcprst_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_i       (pkt),
    .pkt_valid_i (pkt_valid),
    .pkt_ready_o (pkt_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/tcprst_seg.sv
`default_nettype none

module tcprst_seg
  import tcprst_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tcprst_in_if.sink   in_i,
  output hdr_t        hdr_o,
  output logic        hdr_valid_o,
  input  wire logic   hdr_ready_i
);

  req_t req_q;
  logic req_valid_q;
  hdr_t hdr_q;
  hdr_t hdr_d;
  logic hdr_valid_q;
  logic hdr_load;

  assign hdr_load   = !hdr_valid_q || hdr_ready_i;
  assign in_i.ready = hdr_load || !req_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      hdr_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        req_valid_q <= in_i.valid;
      end
      if (hdr_load) begin
        hdr_valid_q <= req_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      req_q.is_v6         <= in_i.is_v6;
      req_q.peer_addr_hi  <= in_i.peer_addr_hi;
      req_q.peer_addr_lo  <= in_i.peer_addr_lo;
      req_q.local_addr_hi <= in_i.local_addr_hi;
      req_q.local_addr_lo <= in_i.local_addr_lo;
      req_q.peer_port     <= in_i.peer_port;
      req_q.local_port    <= in_i.local_port;
      req_q.seq_in        <= in_i.seq_in;
      req_q.ack_in        <= in_i.ack_in;
      req_q.flags_in      <= in_i.flags_in;
      req_q.l3_length     <= in_i.l3_length;
      req_q.header_length <= in_i.header_length;
    end
    if (hdr_load && req_valid_q) begin
      hdr_q <= hdr_d;
    end
  end

  always_comb begin
    logic [15:0] payload;
    logic [16:0] seg;
    // payload length saturates at zero when the headers run past the packet
    payload = (req_q.l3_length > req_q.header_length)
              ? (req_q.l3_length - req_q.header_length) : 16'd0;
    seg = 17'(payload) + 17'(req_q.flags_in[FlagSynBit]) + 17'(req_q.flags_in[FlagFinBit]);
    if (seg == 17'd0) begin
      seg = 17'd1;
    end

    hdr_d.is_v6         = req_q.is_v6;
    hdr_d.peer_addr_hi  = req_q.peer_addr_hi;
    hdr_d.peer_addr_lo  = req_q.peer_addr_lo;
    hdr_d.local_addr_hi = req_q.local_addr_hi;
    hdr_d.local_addr_lo = req_q.local_addr_lo;
    hdr_d.peer_port     = req_q.peer_port;
    hdr_d.local_port    = req_q.local_port;
    if (req_q.flags_in[FlagAckBit]) begin
      hdr_d.seq_out   = req_q.ack_in;
      hdr_d.ack_out   = 32'd0;
      hdr_d.flags_out = RstFlags;
    end else begin
      hdr_d.seq_out   = 32'd0;
      hdr_d.ack_out   = req_q.seq_in + 32'(seg);
      hdr_d.flags_out = RstAckFlags;
    end
  end

  assign hdr_o       = hdr_q;
  assign hdr_valid_o = hdr_valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tcprst_csum.sv
`default_nettype none

module tcprst_csum
  import tcprst_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire hdr_t  hdr_i,
  input  wire logic  hdr_valid_i,
  output logic       hdr_ready_o,
  output pkt_t       pkt_o,
  output logic       pkt_valid_o,
  input  wire logic  pkt_ready_i
);

  sums_t sums_q;
  sums_t sums_d;
  logic  sums_valid_q;
  pkt_t  pkt_q;
  pkt_t  pkt_d;
  logic  pkt_valid_q;
  logic  pkt_load;
  logic  sums_load;

  assign pkt_load    = !pkt_valid_q || pkt_ready_i;
  assign sums_load   = pkt_load || !sums_valid_q;
  assign hdr_ready_o = sums_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_valid_q <= 1'b0;
      pkt_valid_q  <= 1'b0;
    end else begin
      if (sums_load) begin
        sums_valid_q <= hdr_valid_i;
      end
      if (pkt_load) begin
        pkt_valid_q <= sums_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sums_load && hdr_valid_i) begin
      sums_q <= sums_d;
    end
    if (pkt_load && sums_valid_q) begin
      pkt_q <= pkt_d;
    end
  end

  // first half: partial sums of the addresses and of the tcp header words
  always_comb begin
    sums_d.hdr = hdr_i;
    if (hdr_i.is_v6) begin
      sums_d.local_hi_sum = sum4(hdr_i.local_addr_hi);
      sums_d.local_lo_sum = sum4(hdr_i.local_addr_lo);
      sums_d.peer_hi_sum  = sum4(hdr_i.peer_addr_hi);
      sums_d.peer_lo_sum  = sum4(hdr_i.peer_addr_lo);
    end else begin
      sums_d.local_hi_sum = '0;
      sums_d.local_lo_sum = sum4({32'd0, hdr_i.local_addr_lo[31:0]});
      sums_d.peer_hi_sum  = '0;
      sums_d.peer_lo_sum  = sum4({32'd0, hdr_i.peer_addr_lo[31:0]});
    end
    sums_d.tcp_sum = TcpSumW'(hdr_i.local_port) + TcpSumW'(hdr_i.peer_port)
                   + TcpSumW'(hdr_i.seq_out[31:16]) + TcpSumW'(hdr_i.seq_out[15:0])
                   + TcpSumW'(hdr_i.ack_out[31:16]) + TcpSumW'(hdr_i.ack_out[15:0])
                   + TcpSumW'({TcpOffset, hdr_i.flags_out}) + TcpSumW'(PseudoSumBase);
  end

  // second half: fold the checksums and lay out the reply words
  always_comb begin
    logic [TotalW-1:0] tcp_total;
    logic [TotalW-1:0] ip_total;
    logic [15:0]       tcp_csum;
    logic [15:0]       ip_csum;
    hdr_t              h;
    h = sums_q.hdr;
    tcp_total = TotalW'(sums_q.local_hi_sum) + TotalW'(sums_q.local_lo_sum)
              + TotalW'(sums_q.peer_hi_sum) + TotalW'(sums_q.peer_lo_sum)
              + TotalW'(sums_q.tcp_sum);
    ip_total  = TotalW'(Ipv4SumBase) + TotalW'(sums_q.local_lo_sum)
              + TotalW'(sums_q.peer_lo_sum);
    tcp_csum  = csum_fold(tcp_total);
    ip_csum   = csum_fold(ip_total);

    pkt_d.words = '0;
    pkt_d.is_v6 = h.is_v6;
    if (h.is_v6) begin
      pkt_d.last_idx = LastIdxV6;
      pkt_d.words[0] = V6Word0;
      pkt_d.words[1] = h.local_addr_hi;
      pkt_d.words[2] = h.local_addr_lo;
      pkt_d.words[3] = h.peer_addr_hi;
      pkt_d.words[4] = h.peer_addr_lo;
      pkt_d.words[5] = {h.local_port, h.peer_port, h.seq_out};
      pkt_d.words[6] = {h.ack_out, TcpOffset, h.flags_out, 16'd0};
      pkt_d.words[7] = {tcp_csum, 48'd0};
    end else begin
      pkt_d.last_idx = LastIdxV4;
      pkt_d.words[0] = V4Word0;
      pkt_d.words[1] = {TtlHops, ProtoTcp, ip_csum, h.local_addr_lo[31:0]};
      pkt_d.words[2] = {h.peer_addr_lo[31:0], h.local_port, h.peer_port};
      pkt_d.words[3] = {h.seq_out, h.ack_out};
      pkt_d.words[4] = {TcpOffset, h.flags_out, 16'd0, tcp_csum, 16'd0};
    end
  end

  assign pkt_o       = pkt_q;
  assign pkt_valid_o = pkt_valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tcprst_ser.sv
`default_nettype none

module tcprst_ser
  import tcprst_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire pkt_t    pkt_i,
  input  wire logic    pkt_valid_i,
  output logic         pkt_ready_o,
  tcprst_out_if.source out_o
);

  pkt_t            pkt_q;
  logic [IdxW-1:0] idx_q;
  logic            busy_q;
  logic            at_last;
  logic            word_taken;

  assign at_last     = (idx_q == pkt_q.last_idx);
  assign word_taken  = busy_q && out_o.ready;
  // next packet loads in the cycle its predecessor's last word leaves
  assign pkt_ready_o = !busy_q || (word_taken && at_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pkt_ready_o) begin
      busy_q <= pkt_valid_i;
      idx_q  <= '0;
    end else if (word_taken) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_ready_o && pkt_valid_i) begin
      pkt_q <= pkt_i;
    end
  end

  assign out_o.valid       = busy_q;
  assign out_o.packet_word = pkt_q.words[idx_q];
  assign out_o.last_word   = at_last;
  assign out_o.valid_bytes = (at_last && pkt_q.is_v6) ? BytesV6Tail : BytesFull;

endmodule

`default_nettype wire
